// File: hw/rtl/gcpc_pkg.sv
// ----------------------------------------------------------------------------
// gcpc_pkg
// shared constants and types of the gap-constrained pattern counter
// ----------------------------------------------------------------------------
package gcpc_pkg;

  localparam int unsigned MAX_PATTERN_LEN = 8;
  localparam int unsigned GAP_WINDOW      = 256;
  localparam int unsigned MAX_SEQ_LEN     = 1048576;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CNT_W   = 64;
  localparam int unsigned GAP_W   = $clog2(GAP_WINDOW);
  // prefix sums wrap; wide enough to hold any window sum exactly
  localparam int unsigned PREF_W  = CNT_W + GAP_W;
  localparam int unsigned RING_DEPTH = 2 * GAP_WINDOW;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned IDX_W   = $clog2(MAX_SEQ_LEN);
  localparam int unsigned POS_W   = IDX_W + 1;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned LVL_W   = $clog2(MAX_PATTERN_LEN);
  localparam int unsigned MASK_W  = 52;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEAK_MASK     = 3'd4;

  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  typedef logic [PREF_W-1:0] pref_t;

endpackage

// File: hw/rtl/gcpc_ram.sv
// ----------------------------------------------------------------------------
// gcpc_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module gcpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: hw/rtl/gap_constrained_pattern_counter.sv
// ----------------------------------------------------------------------------
// gap_constrained_pattern_counter
// counts gap-constrained occurrences of a pattern in a character stream
// ----------------------------------------------------------------------------
// Characters enter on the s_axis channel, one per request, tdata holding the
// character and tlast marking the final character of a sequence. On the last
// character one result leaves on m_axis: tdata the occurrence total and tuser
// the saturation flag. The block takes one character per cycle unless input
// is stalled; a result passes the stage-2 registers, then the result register.
// Per level a ring memory of prefix sums of partial counts is read at two
// addresses per character (window top and bottom) and written once, so each
// level memory serves one character a cycle while input is not stalled; the
// newest prefix is forwarded from a register.
// The user writes cfg port registers only with no sequence in flight; unchecked.
// Reset clears the sequence state; ring entries are never read before they
// are written in the current sequence, so no clearing pass is needed.
// While a result waits for m_axis_tready, characters are still taken until
// the next last character reaches stage 2, which then stalls input.
// ----------------------------------------------------------------------------
module gap_constrained_pattern_counter
  import gcpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // seq_char
  input  logic                  s_axis_tlast,   // seq_last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [CNT_W-1:0]      m_axis_tdata,   // occurrence_count
  output logic                  m_axis_tuser    // count_saturated
);

  // configuration
  logic [CHAR_W*MAX_PATTERN_LEN-1:0] pat_q;
  logic [LEN_W-1:0]  len_q;
  logic [GAP_W-1:0]  min_gap_q, max_gap_q;
  logic [MASK_W-1:0] weak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      len_q     <= LEN_W'(2);
      min_gap_q <= '0;
      max_gap_q <= GAP_W'(100);
      weak_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_CHARS: pat_q     <= cfg_data_i;
        REG_PATTERN_LEN:   len_q     <= cfg_data_i[LEN_W-1:0];
        REG_MIN_GAP:       min_gap_q <= cfg_data_i[GAP_W-1:0];
        REG_MAX_GAP:       max_gap_q <= cfg_data_i[GAP_W-1:0];
        REG_WEAK_MASK:     weak_q    <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic stall, adv, acc;
  logic s2_valid_q, s2_last_q, s2_drop_q;
  logic out_valid_q;

  assign stall = s2_valid_q && s2_last_q && out_valid_q && !m_axis_tready;
  assign adv   = !stall;
  assign s_axis_tready = adv;
  assign acc   = s_axis_tvalid && adv;

  // stage 1: window addresses
  logic [POS_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] blk_q, blk_d;
  logic [IDX_W-1:0] ci, im1, hi, lo_a, lo, lom1;
  logic             in_range, gap_ok, nonempty, lo_zero, blocker;
  logic [LEN_W-1:0] len_c;
  logic [MAX_PATTERN_LEN-1:0] match;
  logic [5:0]       letter;
  logic             is_letter;

  always_comb begin
    ci       = pos_q[IDX_W-1:0];
    in_range = (pos_q < POS_W'(MAX_SEQ_LEN));
    im1      = ci - IDX_W'(1);
    gap_ok   = (min_gap_q <= max_gap_q) && (ci >= IDX_W'(min_gap_q) + IDX_W'(1));
    hi       = im1 - IDX_W'(min_gap_q);
    lo_a     = (im1 >= IDX_W'(max_gap_q)) ? im1 - IDX_W'(max_gap_q) : '0;
    lo       = (lo_a < blk_q) ? blk_q : lo_a;
    nonempty = gap_ok && (lo <= hi);
    lo_zero  = (lo == '0);
    lom1     = lo - IDX_W'(1);

    len_c = len_q;
    if (len_q < LEN_W'(2)) len_c = LEN_W'(2);
    if (len_q > LEN_W'(MAX_PATTERN_LEN)) len_c = LEN_W'(MAX_PATTERN_LEN);
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      match[k] = (LEN_W'(k) < len_c) && (s_axis_tdata == pat_q[CHAR_W*k +: CHAR_W]);
    end

    is_letter = 1'b1;
    letter    = '0;
    if (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h5a) begin
      letter = 6'(s_axis_tdata - 8'h41);
    end else if (s_axis_tdata >= 8'h61 && s_axis_tdata <= 8'h7a) begin
      letter = 6'(s_axis_tdata - 8'h61 + 8'd26);
    end else begin
      is_letter = 1'b0;
    end
    blocker = is_letter && !weak_q[letter];

    pos_d = pos_q;
    blk_d = blk_q;
    if (acc) begin
      if (in_range) begin
        pos_d = pos_q + POS_W'(1);
        if (blocker) blk_d = ci;
      end
      if (s_axis_tlast) begin
        pos_d = '0;
        blk_d = '0;
      end
    end
  end

  logic [MAX_PATTERN_LEN-1:0] s2_match_q;
  logic [LVL_W-1:0]           s2_top_q;
  logic                       s2_nonempty_q, s2_lo_zero_q;
  logic [RING_AW-1:0]         s2_hi_q, s2_lom1_q, s2_waddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      blk_q      <= '0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s2_drop_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      blk_q <= blk_d;
      if (adv) begin
        s2_valid_q <= acc;
        s2_last_q  <= s_axis_tlast;
        s2_drop_q  <= !in_range;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_match_q    <= match;
      s2_top_q      <= LVL_W'(len_c - LEN_W'(1));
      s2_nonempty_q <= nonempty;
      s2_lo_zero_q  <= lo_zero;
      s2_hi_q       <= hi[RING_AW-1:0];
      s2_lom1_q     <= lom1[RING_AW-1:0];
      s2_waddr_q    <= ci[RING_AW-1:0];
    end
  end

  // stage 2: window sums and prefix update
  pref_t pref_q [MAX_PATTERN_LEN-1];
  pref_t pref_d [MAX_PATTERN_LEN-1];
  pref_t rd_hi [MAX_PATTERN_LEN-1];
  pref_t rd_lo [MAX_PATTERN_LEN-1];
  logic [RING_AW-1:0] last_addr_q;
  logic [CNT_W-1:0]   fresh [MAX_PATTERN_LEN];
  logic [CNT_W-1:0]   total_q, total_d, fin;
  logic               sat_q, sat_d, we;
  pref_t              p_hi, p_lo, diff;
  logic [CNT_W:0]     tsum;

  assign we = adv && s2_valid_q && !s2_drop_q;

  for (genvar g = 0; g < MAX_PATTERN_LEN - 1; g++) begin : g_lvl
    gcpc_ram #(
      .WIDTH (PREF_W),
      .DEPTH (RING_DEPTH)
    ) u_ring (
      .clk_i     (clk_i),
      .we_i      (we),
      .waddr_i   (s2_waddr_q),
      .wdata_i   (pref_d[g]),
      .re_i      (adv),
      .raddr_a_i (hi[RING_AW-1:0]),
      .raddr_b_i (lom1[RING_AW-1:0]),
      .rdata_a_o (rd_hi[g]),
      .rdata_b_o (rd_lo[g])
    );
  end

  always_comb begin
    sat_d   = sat_q || s2_drop_q;
    fresh[0] = CNT_W'(s2_match_q[0]);
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      p_hi = (s2_hi_q == last_addr_q) ? pref_q[k-1] : rd_hi[k-1];
      p_lo = s2_lo_zero_q ? '0 :
             ((s2_lom1_q == last_addr_q) ? pref_q[k-1] : rd_lo[k-1]);
      diff = p_hi - p_lo;
      fresh[k] = '0;
      if (s2_match_q[k] && s2_nonempty_q) begin
        if (diff[PREF_W-1:CNT_W] != '0) begin
          fresh[k] = CNT_TOP;
          sat_d    = 1'b1;
        end else begin
          fresh[k] = diff[CNT_W-1:0];
        end
      end
    end
    for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) begin
      pref_d[k] = pref_q[k] + PREF_W'(fresh[k]);
    end
    total_d = total_q;
    if (!s2_drop_q) begin
      tsum = {1'b0, total_q} + {1'b0, fresh[s2_top_q]};
      if (tsum[CNT_W]) begin
        total_d = CNT_TOP;
        sat_d   = 1'b1;
      end else begin
        total_d = tsum[CNT_W-1:0];
      end
    end else begin
      tsum = '0;
    end
    fin = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) pref_q[k] <= '0;
      last_addr_q <= '0;
      total_q     <= '0;
      sat_q       <= 1'b0;
    end else if (adv && s2_valid_q) begin
      if (s2_last_q) begin
        for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) pref_q[k] <= '0;
        total_q <= '0;
        sat_q   <= 1'b0;
      end else begin
        if (!s2_drop_q) begin
          for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) pref_q[k] <= pref_d[k];
        end
        total_q <= total_d;
        sat_q   <= sat_d;
      end
      if (!s2_drop_q) last_addr_q <= s2_waddr_q;
    end
  end

  // result register
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s2_valid_q && s2_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q && s2_last_q) begin
      out_cnt_q <= fin;
      out_sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_cnt_q;
  assign m_axis_tuser  = out_sat_q;

endmodule

// File: hw/rtl/gcpc_checker.sv
// ----------------------------------------------------------------------------
// gcpc_checker
// port-level checks of the gap-constrained pattern counter
// ----------------------------------------------------------------------------
module gcpc_checker
  import gcpc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              s_axis_tlast,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [CNT_W-1:0]  m_axis_tdata,
  input logic              m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a last request");

endmodule

bind gap_constrained_pattern_counter gcpc_checker u_gcpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
